### design/undirected_graph_cycle_detect_macros.svh
// Assertion macros for the undirected graph cycle detector
`ifndef UNDIRECTED_GRAPH_CYCLE_DETECT_MACROS_SVH
`define UNDIRECTED_GRAPH_CYCLE_DETECT_MACROS_SVH
`ifndef SYNTHESIS
`define UGCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define UGCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define UGCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define UGCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/ugcd_pkg.sv
// Shared constants and types for the undirected graph cycle detector
package ugcd_pkg;
	localparam int MAX_VERTICES = 256;
	localparam int MAX_EDGES = 1024;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int TW = $clog2(MAX_EDGES + 1);
	localparam int SW = $clog2(MAX_VERTICES + 1);
	localparam int FW = VW + EW + 1 + TW;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	typedef struct packed {
		logic [VW-1:0] vertex;
		logic [EW-1:0] in_edge;
		logic has_in;
		logic [TW-1:0] cursor;
	} frame_t;
endpackage

### design/undirected_graph_cycle_detect.sv
// Top level of the undirected graph cycle detector
// Edge adds (cmd 0) are handled while idle and busy stays low. An evaluate (cmd 1) runs a
// depth-first walk and holds busy high until the result. It tries each seed vertex in turn
// and scans every stored edge once per vertex it visits, via the top, edge and exam states,
// stopping at the first cycle. A pop reloads the frame from the stack RAM, but a root pop
// returns to the seeds. A sweep of all 256 entries clears the visited marks. The done state
// registers the result, which appears for one cycle on the done strobe, and busy drops in
// that same cycle. The receiver cannot hold the result off. Start is ignored while busy is high.
module undirected_graph_cycle_detect (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cmd,
	input logic [7:0] node_a,
	input logic [7:0] node_b,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [8:0] cfg_data,
	output logic done,
	output logic has_cycle,
	output logic [1:0] status
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SEED = 4'd1;
	localparam logic [3:0] S_TOP = 4'd2;
	localparam logic [3:0] S_EDGE = 4'd3;
	localparam logic [3:0] S_EXAM = 4'd4;
	localparam logic [3:0] S_VIS = 4'd5;
	localparam logic [3:0] S_POP = 4'd6;
	localparam logic [3:0] S_CLR = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;
	localparam logic [3:0] S_POPW = 4'd9;

	logic [3:0] state_q;
	logic [8:0] vcount_q;
	logic [ugcd_pkg::TW-1:0] etotal_q;
	logic [1:0] err_q;
	logic [ugcd_pkg::CW-1:0] seed_q;
	logic [ugcd_pkg::SW-1:0] sp_q;
	ugcd_pkg::frame_t top_q;
	logic [ugcd_pkg::VW:0] clr_q;
	logic cyc_q;
	logic [ugcd_pkg::MAX_VERTICES-1:0] vis_q;

	logic [ugcd_pkg::CW-1:0] cnt;
	logic take;
	logic [15:0] e_wdata, e_rdata;
	logic [ugcd_pkg::EW-1:0] e_raddr;
	logic st_we;
	logic [ugcd_pkg::VW-1:0] st_waddr, st_raddr;
	ugcd_pkg::frame_t st_wdata, st_rdata;
	logic [ugcd_pkg::VW-1:0] ea, eb, nb;
	logic ok_a, ok_b, hit;
	logic [ugcd_pkg::EW-1:0] cur_e;

	assign cnt = (vcount_q > 9'(ugcd_pkg::MAX_VERTICES)) ?
		ugcd_pkg::CW'(ugcd_pkg::MAX_VERTICES) : ugcd_pkg::CW'(vcount_q);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign take = start && !busy;
	assign e_wdata = {node_a, node_b};
	assign cur_e = top_q.cursor[ugcd_pkg::EW-1:0];
	assign e_raddr = cur_e;
	assign ea = e_rdata[15:8];
	assign eb = e_rdata[7:0];
	assign ok_a = ugcd_pkg::CW'(ea) < cnt;
	assign ok_b = ugcd_pkg::CW'(eb) < cnt;
	assign nb = (ea == top_q.vertex) ? eb : ea;
	assign hit = ok_a && ok_b && (ea == top_q.vertex || eb == top_q.vertex)
		&& !(top_q.has_in && top_q.in_edge == cur_e);

	ugcd_ram #(.WIDTH(16), .DEPTH(ugcd_pkg::MAX_EDGES)) u_edges (
		.clk(clk),
		.we(take && !cmd && ugcd_pkg::CW'(node_a) < cnt && ugcd_pkg::CW'(node_b) < cnt
			&& etotal_q < ugcd_pkg::TW'(ugcd_pkg::MAX_EDGES)),
		.waddr(etotal_q[ugcd_pkg::EW-1:0]),
		.wdata(e_wdata),
		.raddr(e_raddr),
		.rdata(e_rdata)
	);

	ugcd_ram #(.WIDTH(ugcd_pkg::FW), .DEPTH(ugcd_pkg::MAX_VERTICES)) u_stack (
		.clk(clk),
		.we(st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	assign st_we = (state_q == S_EXAM) && hit && !vis_q[nb]
		&& sp_q < ugcd_pkg::SW'(ugcd_pkg::MAX_VERTICES);
	assign st_waddr = ugcd_pkg::VW'(sp_q - 1'b1);
	assign st_wdata = '{vertex: top_q.vertex, in_edge: top_q.in_edge, has_in: top_q.has_in,
		cursor: top_q.cursor + 1'b1};
	assign st_raddr = ugcd_pkg::VW'(sp_q - 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcount_q <= 9'd256;
			etotal_q <= '0;
			err_q <= ugcd_pkg::ST_OK;
			seed_q <= '0;
			sp_q <= '0;
			top_q <= '0;
			clr_q <= '0;
			cyc_q <= 1'b0;
			vis_q <= '0;
			done <= 1'b0;
			has_cycle <= 1'b0;
			status <= ugcd_pkg::ST_OK;
		end else begin
			done <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						vcount_q <= cfg_data;
					end
					if (take) begin
						if (cmd) begin
							seed_q <= '0;
							cyc_q <= 1'b0;
							state_q <= S_SEED;
						end else if (ugcd_pkg::CW'(node_a) >= cnt
							|| ugcd_pkg::CW'(node_b) >= cnt) begin
							err_q <= ugcd_pkg::ST_RANGE;
						end else if (etotal_q >= ugcd_pkg::TW'(ugcd_pkg::MAX_EDGES)) begin
							if (err_q != ugcd_pkg::ST_RANGE) begin
								err_q <= ugcd_pkg::ST_FULL;
							end
						end else begin
							etotal_q <= etotal_q + 1'b1;
						end
					end
				end
				S_SEED: begin
					if (seed_q >= cnt) begin
						clr_q <= '0;
						state_q <= S_CLR;
					end else begin
						if (!vis_q[ugcd_pkg::VW'(seed_q)]) begin
							vis_q[ugcd_pkg::VW'(seed_q)] <= 1'b1;
							top_q <= '{vertex: ugcd_pkg::VW'(seed_q), in_edge: '0,
								has_in: 1'b0, cursor: '0};
							sp_q <= ugcd_pkg::SW'(1);
							state_q <= S_TOP;
						end
						seed_q <= seed_q + 1'b1;
					end
				end
				S_TOP: begin
					if (top_q.cursor >= etotal_q) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					state_q <= S_EXAM;
				end
				S_EXAM: begin
					if (hit && vis_q[nb]) begin
						cyc_q <= 1'b1;
						clr_q <= '0;
						state_q <= S_CLR;
					end else begin
						state_q <= S_TOP;
						if (st_we) begin
							vis_q[nb] <= 1'b1;
							top_q <= '{vertex: nb, in_edge: cur_e, has_in: 1'b1,
								cursor: '0};
							sp_q <= sp_q + 1'b1;
						end else begin
							top_q.cursor <= top_q.cursor + 1'b1;
						end
					end
				end
				S_POP: begin
					if (sp_q == ugcd_pkg::SW'(1)) begin
						sp_q <= '0;
						state_q <= S_SEED;
					end else begin
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					top_q <= st_rdata;
					sp_q <= sp_q - 1'b1;
					state_q <= S_TOP;
				end
				S_CLR: begin
					vis_q[clr_q[ugcd_pkg::VW-1:0]] <= 1'b0;
					if (clr_q == (ugcd_pkg::VW+1)'(ugcd_pkg::MAX_VERTICES - 1)) begin
						state_q <= S_DONE;
					end
					clr_q <= clr_q + 1'b1;
				end
				S_DONE: begin
					has_cycle <= cyc_q;
					status <= err_q;
					err_q <= ugcd_pkg::ST_OK;
					etotal_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "undirected_graph_cycle_detect_macros.svh"
	`UGCD_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`UGCD_ASSERT_IMPL(a_idle_ready, clk, arst_n, cfg_ready, !busy)
	`UGCD_ASSERT_IMPL(a_sp_range, clk, arst_n, busy, sp_q <= ugcd_pkg::SW'(ugcd_pkg::MAX_VERTICES))
	`UGCD_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
endmodule

### design/ugcd_ram.sv
// Generic single-port-write, one-read RAM with registered read
module ugcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### test/undirected_graph_cycle_detect_test.sv
// Testbench for the undirected graph cycle detector: directed table, edge-store overflow, then random graphs.
`timescale 1ns / 100ps

module undirected_graph_cycle_detect_test;
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE = 300;

	typedef enum logic [1:0] {ROW_ADD, ROW_EVAL, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		int a;
		int b;
		int cfg;
		bit pinned;
		bit pin_cycle;
		logic [1:0] pin_status;
	} row_t;

	typedef struct {
		bit cyc;
		logic [1:0] st;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic cmd = 0;
	logic [7:0] node_a = 0;
	logic [7:0] node_b = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [8:0] cfg_data = 0;
	logic done;
	logic has_cycle;
	logic [1:0] status;

	undirected_graph_cycle_detect DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.node_a(node_a), .node_b(node_b), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .done(done), .has_cycle(has_cycle), .status(status)
	);

	always #4 clk = ~clk;

	// graph mirror
	int vcount = 256;
	logic [7:0] end_a [ugcd_pkg::MAX_EDGES];
	logic [7:0] end_b [ugcd_pkg::MAX_EDGES];
	int edge_cnt = 0;
	logic [1:0] fault = ugcd_pkg::ST_OK;
	bit seen [ugcd_pkg::MAX_VERTICES];
	int stk_v [ugcd_pkg::MAX_VERTICES];
	int stk_in [ugcd_pkg::MAX_VERTICES];
	int stk_cur [ugcd_pkg::MAX_VERTICES];

	verdict_t verdicts [$];
	int fails = 0;
	int cycles = 0;
	bit calm = 0;

	function automatic int limit_count();
		return vcount > ugcd_pkg::MAX_VERTICES ? ugcd_pkg::MAX_VERTICES : vcount;
	endfunction

	function automatic bit graph_has_loop();
		int n, sp, e, v, nb;
		n = limit_count();
		foreach (seen[i]) seen[i] = 0;
		for (int s = 0; s < n; s++) begin
			if (seen[s]) continue;
			seen[s] = 1;
			stk_v[0] = s;
			stk_in[0] = -1;
			stk_cur[0] = 0;
			sp = 1;
			while (sp > 0) begin
				if (stk_cur[sp-1] >= edge_cnt) begin
					sp--;
					continue;
				end
				e = stk_cur[sp-1];
				stk_cur[sp-1]++;
				v = stk_v[sp-1];
				if (end_a[e] >= n || end_b[e] >= n) continue;
				if (end_a[e] == v) nb = end_b[e];
				else if (end_b[e] == v) nb = end_a[e];
				else continue;
				if (stk_in[sp-1] == e) continue;
				if (seen[nb]) return 1;
				if (sp >= ugcd_pkg::MAX_VERTICES) continue;
				seen[nb] = 1;
				stk_v[sp] = nb;
				stk_in[sp] = e;
				stk_cur[sp] = 0;
				sp++;
			end
		end
		return 0;
	endfunction

	function automatic verdict_t graph_step(logic c, int a, int b);
		verdict_t r;
		int n;
		r.cyc = 0;
		r.st = ugcd_pkg::ST_OK;
		if (c == CMD_ADD) begin
			n = limit_count();
			if (a >= n || b >= n) fault = ugcd_pkg::ST_RANGE;
			else if (edge_cnt >= ugcd_pkg::MAX_EDGES) begin
				if (fault != ugcd_pkg::ST_RANGE) fault = ugcd_pkg::ST_FULL;
			end else begin
				end_a[edge_cnt] = 8'(a);
				end_b[edge_cnt] = 8'(b);
				edge_cnt++;
			end
		end else begin
			r.cyc = graph_has_loop();
			r.st = fault;
			edge_cnt = 0;
			fault = ugcd_pkg::ST_OK;
		end
		return r;
	endfunction

	task automatic idle_gap();
		if (!calm && $urandom_range(0, 5) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic issue(logic c, int a, int b, bit pinned = 0, bit pc = 0,
			logic [1:0] ps = ugcd_pkg::ST_OK);
		verdict_t r;
		idle_gap();
		start <= 1;
		cmd <= c;
		node_a <= 8'(a);
		node_b <= 8'(b);
		do @(posedge clk); while (busy);
		r = graph_step(c, a, b);
		if (c == CMD_EVAL) begin
			if (pinned) begin
				r.cyc = pc;
				r.st = ps;
			end
			verdicts = {verdicts, r};
		end
	endtask

	task automatic write_count(int v);
		start <= 0;
		wait (verdicts.size() == 0);
		repeat (20) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= 9'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		vcount = v;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && done) begin
			if (verdicts.size() == 0) begin
				$error("result with nothing expected: has_cycle %0d status %0d",
					has_cycle, status);
				fails++;
			end else begin
				w = verdicts.pop_front();
				if (has_cycle !== w.cyc) begin
					$error("has_cycle expected %0d got %0d", w.cyc, has_cycle);
					fails++;
				end
				if (status !== w.st) begin
					$error("status expected %0d got %0d", w.st, status);
					fails++;
				end
			end
		end
	end

	row_t rows [] = '{
		'{ROW_ADD, 0, 1, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 1, 2, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_EVAL, 0, 0, 0, 1, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 255, 255, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_EVAL, 255, 255, 0, 1, 1, ugcd_pkg::ST_OK},
		'{ROW_ADD, 3, 4, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 4, 3, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_EVAL, 0, 0, 0, 1, 1, ugcd_pkg::ST_OK},
		'{ROW_EVAL, 0, 0, 0, 1, 0, ugcd_pkg::ST_OK},
		'{ROW_CFG, 0, 0, 4, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 0, 200, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 0, 1, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 1, 2, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 2, 0, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_EVAL, 0, 0, 0, 1, 1, ugcd_pkg::ST_RANGE},
		'{ROW_CFG, 0, 0, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 0, 0, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_EVAL, 0, 0, 0, 1, 0, ugcd_pkg::ST_RANGE},
		'{ROW_CFG, 0, 0, 511, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 255, 0, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_EVAL, 0, 0, 0, 1, 0, ugcd_pkg::ST_OK},
		'{ROW_CFG, 0, 0, 8, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 0, 7, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 7, 5, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_ADD, 5, 0, 0, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_CFG, 0, 0, 6, 0, 0, ugcd_pkg::ST_OK},
		'{ROW_EVAL, 0, 0, 0, 0, 0, ugcd_pkg::ST_OK}
	};

	initial begin
		int n, ne, a, b, sent, pick;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_ADD: issue(CMD_ADD, rows[i].a, rows[i].b);
				ROW_EVAL: issue(CMD_EVAL, rows[i].a, rows[i].b, rows[i].pinned,
					rows[i].pin_cycle, rows[i].pin_status);
				default: write_count(rows[i].cfg);
			endcase
		end

		// overflow the edge store, then mix in a range fault
		write_count(2);
		for (int i = 0; i < ugcd_pkg::MAX_EDGES + 3; i++) issue(CMD_ADD, 0, 1);
		issue(CMD_EVAL, 0, 0, 1, 1, ugcd_pkg::ST_FULL);
		for (int i = 0; i < ugcd_pkg::MAX_EDGES + 1; i++) issue(CMD_ADD, 1, 0);
		issue(CMD_ADD, 0, 9);
		issue(CMD_ADD, 1, 1);
		issue(CMD_EVAL, 0, 0, 1, 1, ugcd_pkg::ST_RANGE);

		sent = 0;
		while (sent < 400) begin
			if (sent > 340) calm = 1;
			pick = $urandom_range(0, 19);
			if (pick == 0) n = 0;
			else if (pick == 1) n = 1;
			else if (pick == 2) n = $urandom_range(256, 511);
			else if (pick == 3) n = 256;
			else n = $urandom_range(2, 16);
			write_count(n);
			ne = $urandom_range(0, 14);
			for (int i = 0; i < ne; i++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0 || n < 2) begin
					a = $urandom_range(0, 255);
					b = $urandom_range(0, 255);
				end else if (pick < 6) begin
					a = $urandom_range(1, (n > 256 ? 256 : n) - 1);
					b = $urandom_range(0, a - 1);
				end else begin
					a = $urandom_range(0, (n > 256 ? 256 : n) - 1);
					b = $urandom_range(0, (n > 256 ? 256 : n) - 1);
				end
				issue(CMD_ADD, a, b);
				sent++;
				if (i == ne / 2 && $urandom_range(0, 9) == 0) write_count($urandom_range(1, n));
			end
			issue(CMD_EVAL, $urandom_range(0, 255), $urandom_range(0, 255));
			sent++;
		end

		start <= 0;
		wait (verdicts.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0 && verdicts.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+design
design/ugcd_pkg.sv
design/ugcd_ram.sv
design/undirected_graph_cycle_detect.sv
test/undirected_graph_cycle_detect_test.sv
